/* src/atp_pkg.sv */
// ----------------------------------------------------------------------------
// atp_pkg
// Shared types, constants and the arctangent table of the tilt block.
// ----------------------------------------------------------------------------
`default_nettype none
package atp_pkg;
   localparam int CORDIC_STAGES = 16;
   localparam int TABLE_LEN = 24;
   localparam int CORDIC_N = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

   localparam int AXIS_W = 15;
   localparam int SUM_W = 28;
   localparam int ROOT_W = 32;
   localparam int SQRT_N = ROOT_W;
   localparam int REM_W = ROOT_W + 3;
   localparam int SQRT_SHIFT = 36;
   localparam int NUM_SHIFT = 18;
   localparam int XY_W = 36;
   localparam int Z_W = 26;
   localparam int ANGLE_W = 15;
   localparam int RIGHT_ANGLE = 11520;
   localparam int ROUND_BIAS = 256;
   localparam int ROUND_SHIFT = 9;

   localparam int LANE_LAT = 1 + SQRT_N + CORDIC_N;

   typedef logic signed [AXIS_W-1:0] axis_type;
   typedef logic signed [Z_W-1:0] angle_z_type;

   typedef struct packed {
      logic num_zero;
      logic num_neg;
      logic den_zero;
   } lane_status_type;

   localparam logic [Z_W-1:0] ATAN_TABLE [0:TABLE_LEN-1] = '{
      26'd2949120, 26'd1740967, 26'd919879, 26'd466945, 26'd234379, 26'd117304,
      26'd58670, 26'd29335, 26'd14668, 26'd7334, 26'd3667, 26'd1833,
      26'd917, 26'd458, 26'd229, 26'd115, 26'd57, 26'd29,
      26'd14, 26'd7, 26'd4, 26'd2, 26'd1, 26'd0
   };
endpackage
`default_nettype wire

/* src/atp_if.sv */
// ----------------------------------------------------------------------------
// atp_req_if / atp_rsp_if
// Valid/ready channels for samples and tilt results.
// ----------------------------------------------------------------------------
`default_nettype none
interface atp_req_if;
   logic valid;
   logic ready;
   logic [15:0] x_word;
   logic [15:0] y_word;
   logic [15:0] z_word;
   modport source (output valid, x_word, y_word, z_word, input ready);
   modport sink (input valid, x_word, y_word, z_word, output ready);
endinterface

interface atp_rsp_if;
   logic valid;
   logic ready;
   logic signed [14:0] accel_x;
   logic signed [14:0] accel_y;
   logic signed [14:0] accel_z;
   logic signed [14:0] pitch;
   logic signed [14:0] roll;
   modport source (output valid, accel_x, accel_y, accel_z, pitch, roll, input ready);
   modport sink (input valid, accel_x, accel_y, accel_z, pitch, roll, output ready);
endinterface
`default_nettype wire

/* src/accel_tilt_pitch_roll.sv */
// ----------------------------------------------------------------------------
// accel_tilt_pitch_roll
// Accelerometer sample to axis values, pitch and roll.
// ----------------------------------------------------------------------------
// One sample is accepted per cycle while the output is not stalled, and one
// result leaves per sample, in order. The pipeline holds one decode register,
// one squaring register, 32 square root stages (one root bit each),
// one CORDIC stage per iteration and the output register. The pitch and roll
// lanes run side by side; a stalled output holds the whole pipeline.
`default_nettype none
module accel_tilt_pitch_roll (
   input wire logic clock,
   input wire logic reset,
   atp_req_if.sink  req_chan,
   atp_rsp_if.source rsp_chan
);
   localparam int LL = atp_pkg::LANE_LAT;
   localparam int VL = LL + 2;

   logic adv;
   logic [VL-1:0] valid_ff, valid_in;

   assign adv = !valid_ff[VL-1] || rsp_chan.ready;
   assign req_chan.ready = adv;

   always_comb begin
      valid_in = {valid_ff[VL-2:0], req_chan.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else if (adv) valid_ff <= valid_in;
   end

   // decode: bits 15:2 signed, negated
   atp_pkg::axis_type ax_ff, ay_ff, az_ff;
   function automatic atp_pkg::axis_type decode(logic [15:0] w);
      return -atp_pkg::axis_type'({w[15], w[15:2]});
   endfunction

   always_ff @(posedge clock) begin
      if (adv) begin
         ax_ff <= decode(req_chan.x_word);
         ay_ff <= decode(req_chan.y_word);
         az_ff <= decode(req_chan.z_word);
      end
   end

   atp_pkg::angle_z_type pitch_z, roll_z;
   atp_pkg::lane_status_type pitch_st, roll_st;

   atp_lane u_pitch (
      .clock(clock), .enable(adv), .num(ax_ff), .a(ay_ff), .b(az_ff),
      .z_out(pitch_z), .status_out(pitch_st)
   );
   atp_lane u_roll (
      .clock(clock), .enable(adv), .num(ay_ff), .a(ax_ff), .b(az_ff),
      .z_out(roll_z), .status_out(roll_st)
   );

   // axis values ride alongside the lanes
   atp_pkg::axis_type dx_ff [0:LL-1];
   atp_pkg::axis_type dy_ff [0:LL-1];
   atp_pkg::axis_type dz_ff [0:LL-1];
   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff[0] <= ax_ff;
         dy_ff[0] <= ay_ff;
         dz_ff[0] <= az_ff;
         for (int i = 1; i < LL; i++) begin
            dx_ff[i] <= dx_ff[i-1];
            dy_ff[i] <= dy_ff[i-1];
            dz_ff[i] <= dz_ff[i-1];
         end
      end
   end

   atp_merge u_merge (
      .clock(clock), .enable(adv),
      .pitch_z(pitch_z), .pitch_st(pitch_st), .roll_z(roll_z), .roll_st(roll_st),
      .ax(dx_ff[LL-1]), .ay(dy_ff[LL-1]), .az(dz_ff[LL-1]),
      .ax_out(rsp_chan.accel_x), .ay_out(rsp_chan.accel_y), .az_out(rsp_chan.accel_z),
      .pitch_out(rsp_chan.pitch), .roll_out(rsp_chan.roll)
   );

   assign rsp_chan.valid = valid_ff[VL-1];

`ifndef ASSERT_OFF
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready == (!rsp_chan.valid || rsp_chan.ready))
      else $error("input ready does not follow output stall");
   a_pitch_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.accel_x == '0) |-> (rsp_chan.pitch == '0))
      else $error("pitch nonzero with zero x");
   a_roll_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.accel_y == '0) |-> (rsp_chan.roll == '0))
      else $error("roll nonzero with zero y");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.pitch <= 15'sd11520 && rsp_chan.pitch >= -15'sd11520))
      else $error("pitch out of range");
`endif
endmodule
`default_nettype wire

/* src/atp_lane.sv */
// ----------------------------------------------------------------------------
// atp_lane
// One angle: sum of squares, pipelined square root, pipelined CORDIC.
// ----------------------------------------------------------------------------
`default_nettype none
module atp_lane (
   input  wire logic                     clock,
   input  wire logic                     enable,
   input  wire atp_pkg::axis_type        num,
   input  wire atp_pkg::axis_type        a,
   input  wire atp_pkg::axis_type        b,
   output atp_pkg::angle_z_type          z_out,
   output atp_pkg::lane_status_type      status_out
);
   localparam int SW = atp_pkg::SUM_W;
   localparam int RW = atp_pkg::ROOT_W;
   localparam int MW = atp_pkg::REM_W;
   localparam int SN = atp_pkg::SQRT_N;
   localparam int CN = atp_pkg::CORDIC_N;
   localparam int XW = atp_pkg::XY_W;
   localparam int ZW = atp_pkg::Z_W;
   localparam int VW = 2 * SN;

   // sum of squares stage
   logic [SW-1:0] sum_ff;
   atp_pkg::axis_type num_ff;
   logic signed [2*atp_pkg::AXIS_W-1:0] aa, bb;

   assign aa = a * a;
   assign bb = b * b;

   always_ff @(posedge clock) begin
      if (enable) begin
         sum_ff <= SW'(aa) + SW'(bb);
         num_ff <= num;
      end
   end

   // square root, one result bit per stage
   logic [SW-1:0] s_sum_ff [0:SN];
   logic [MW-1:0] s_rem_ff [0:SN];
   logic [RW-1:0] s_root_ff [0:SN];
   atp_pkg::axis_type s_num_ff [0:SN];

   always_comb begin
      s_sum_ff[0] = sum_ff;
      s_rem_ff[0] = '0;
      s_root_ff[0] = '0;
      s_num_ff[0] = num_ff;
   end

   for (genvar k = 0; k < SN; k++) begin : g_sqrt
      localparam int I = SN - 1 - k;
      logic [VW-1:0] v;
      logic [MW-1:0] rem_sh, trial;
      logic [MW-1:0] rem_in;
      logic [RW-1:0] root_in;
      assign v = VW'({s_sum_ff[k], {atp_pkg::SQRT_SHIFT{1'b0}}});
      assign rem_sh = {s_rem_ff[k][MW-3:0], v[2*I+1], v[2*I]};
      assign trial = {1'b0, s_root_ff[k], 2'b01};
      always_comb begin
         if (rem_sh >= trial) begin
            rem_in = rem_sh - trial;
            root_in = {s_root_ff[k][RW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            root_in = {s_root_ff[k][RW-2:0], 1'b0};
         end
      end
      logic [SW-1:0] sum_q;
      logic [MW-1:0] rem_q;
      logic [RW-1:0] root_q;
      atp_pkg::axis_type num_q;
      always_ff @(posedge clock) begin
         if (enable) begin
            sum_q <= s_sum_ff[k];
            rem_q <= rem_in;
            root_q <= root_in;
            num_q <= s_num_ff[k];
         end
      end
      assign s_sum_ff[k+1] = sum_q;
      assign s_rem_ff[k+1] = rem_q;
      assign s_root_ff[k+1] = root_q;
      assign s_num_ff[k+1] = num_q;
   end

   // CORDIC vectoring
   logic signed [XW-1:0] c_x [0:CN];
   logic signed [XW-1:0] c_y [0:CN];
   logic signed [ZW-1:0] c_z [0:CN];
   atp_pkg::lane_status_type c_st [0:CN];

   always_comb begin
      c_x[0] = XW'(s_root_ff[SN]);
      c_y[0] = XW'(s_num_ff[SN]) <<< atp_pkg::NUM_SHIFT;
      c_z[0] = '0;
      c_st[0].num_zero = (s_num_ff[SN] == '0);
      c_st[0].num_neg = s_num_ff[SN][atp_pkg::AXIS_W-1];
      c_st[0].den_zero = (s_root_ff[SN] == '0);
   end

   for (genvar j = 0; j < CN; j++) begin : g_cordic
      logic signed [XW-1:0] dx, dy, x_q, y_q;
      logic signed [ZW-1:0] z_q;
      atp_pkg::lane_status_type st_q;
      assign dx = c_y[j] >>> j;
      assign dy = c_x[j] >>> j;
      always_ff @(posedge clock) begin
         if (enable) begin
            if (!c_y[j][XW-1]) begin
               x_q <= c_x[j] + dx;
               y_q <= c_y[j] - dy;
               z_q <= c_z[j] + signed'(atp_pkg::ATAN_TABLE[j]);
            end else begin
               x_q <= c_x[j] - dx;
               y_q <= c_y[j] + dy;
               z_q <= c_z[j] - signed'(atp_pkg::ATAN_TABLE[j]);
            end
            st_q <= c_st[j];
         end
      end
      assign c_x[j+1] = x_q;
      assign c_y[j+1] = y_q;
      assign c_z[j+1] = z_q;
      assign c_st[j+1] = st_q;
   end

   assign z_out = c_z[CN];
   assign status_out = c_st[CN];
endmodule
`default_nettype wire

/* src/atp_merge.sv */
// ----------------------------------------------------------------------------
// atp_merge
// Rounds, saturates and resolves special cases for both lanes; output register.
// ----------------------------------------------------------------------------
`default_nettype none
module atp_merge (
   input  wire logic                     clock,
   input  wire logic                     enable,
   input  wire atp_pkg::angle_z_type     pitch_z,
   input  wire atp_pkg::lane_status_type pitch_st,
   input  wire atp_pkg::angle_z_type     roll_z,
   input  wire atp_pkg::lane_status_type roll_st,
   input  wire atp_pkg::axis_type        ax,
   input  wire atp_pkg::axis_type        ay,
   input  wire atp_pkg::axis_type        az,
   output atp_pkg::axis_type             ax_out,
   output atp_pkg::axis_type             ay_out,
   output atp_pkg::axis_type             az_out,
   output logic signed [atp_pkg::ANGLE_W-1:0] pitch_out,
   output logic signed [atp_pkg::ANGLE_W-1:0] roll_out
);
   localparam int ZW = atp_pkg::Z_W;
   localparam int AW = atp_pkg::ANGLE_W;
   localparam logic signed [ZW:0] RA = (ZW+1)'(atp_pkg::RIGHT_ANGLE);

   function automatic logic signed [AW-1:0] finish(atp_pkg::angle_z_type z,
                                                   atp_pkg::lane_status_type st);
      logic signed [ZW:0] r;
      logic signed [AW-1:0] res;
      r = ((ZW+1)'(z) + (ZW+1)'(atp_pkg::ROUND_BIAS)) >>> atp_pkg::ROUND_SHIFT;
      if (st.num_zero) res = '0;
      else if (st.den_zero) res = st.num_neg ? -AW'(atp_pkg::RIGHT_ANGLE)
                                             : AW'(atp_pkg::RIGHT_ANGLE);
      else if (r > RA) res = AW'(atp_pkg::RIGHT_ANGLE);
      else if (r < -RA) res = -AW'(atp_pkg::RIGHT_ANGLE);
      else res = r[AW-1:0];
      return res;
   endfunction

   atp_pkg::axis_type ax_ff, ay_ff, az_ff;
   logic signed [AW-1:0] pitch_ff, roll_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         ax_ff <= ax;
         ay_ff <= ay;
         az_ff <= az;
         pitch_ff <= finish(pitch_z, pitch_st);
         roll_ff <= finish(roll_z, roll_st);
      end
   end

   assign ax_out = ax_ff;
   assign ay_out = ay_ff;
   assign az_out = az_ff;
   assign pitch_out = pitch_ff;
   assign roll_out = roll_ff;
endmodule
`default_nettype wire
